>>> rtl/nfsp_pkg.sv
package nfsp_pkg;

    // Default grid size.
    localparam int NFSP_NUM_ROWS = 64;
    localparam int NFSP_SITES    = 256;

    // Field and datapath widths.
    localparam int WX_W    = 21;
    localparam int SPAN_W  = 9;
    localparam int PITCH_W = 12;
    localparam int XW      = 22;
    localparam int YW      = 22;
    localparam int CW      = 24;
    localparam int DIST_W  = 25;
    localparam int LVL_N   = 9;
    localparam int LVL_W   = 4;
    localparam int DIVQ_W  = 20;
    localparam int DIVC_W  = 5;

    localparam logic [21:0] DISP_MAX = 22'h3FFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MASK,
        ST_SCAN,
        ST_DRAIN,
        ST_WB_RD,
        ST_WB_WR,
        ST_OUT
    } nfsp_state_t;

    // Per-request constants seen by the row evaluator.
    typedef struct packed {
        logic signed [WX_W-1:0]    wx;
        logic signed [WX_W-1:0]    wy;
        logic [PITCH_W-1:0]        sw;
        logic [LVL_W-1:0]          plog;
        logic [SPAN_W-1:0]         pdiff;
    } nfsp_req_t;

    // Best candidate of one row.
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [DIST_W-1:0] cost;
        logic [XW-1:0]     x;
        logic [YW-1:0]     y;
    } nfsp_cand_t;

    // Index of the highest set bit.
    function automatic logic [LVL_W-1:0] msb_pos(input logic [SPAN_W-1:0] v);
        logic [LVL_W-1:0] p;
        p = '0;
        for (int i = 0; i < SPAN_W; i++)
        begin
            if (v[i])
            begin
                p = LVL_W'(i);
            end
        end
        return p;
    endfunction

endpackage

>>> rtl/nfsp_ram.sv
module nfsp_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/nfsp_div.sv
module nfsp_div
    import nfsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVQ_W-1:0] dividend,
    input  logic [PITCH_W-1:0] divisor,
    output logic              done,
    output logic [DIVQ_W-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIVC_W-1:0] cnt_reg;
    logic [DIVQ_W-1:0] q_reg;
    logic [PITCH_W-1:0] rem_reg;
    logic [PITCH_W-1:0] div_reg;
    logic [PITCH_W:0]  trial;
    logic              qbit;
    logic [PITCH_W:0]  rem_next;

    // One restoring step per cycle.
    always_comb
    begin
        trial = {rem_reg, q_reg[DIVQ_W-1]};
        qbit  = (trial >= {1'b0, div_reg});
        rem_next = qbit ? (trial - {1'b0, div_reg}) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIVC_W'(DIVQ_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DIVQ_W-2:0], qbit};
            rem_reg <= rem_next[PITCH_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> rtl/nfsp_eval.sv
module nfsp_eval
    import nfsp_pkg::*;
#(
    parameter int NUM_ROWS = NFSP_NUM_ROWS,
    parameter int SITES_PER_ROW = NFSP_SITES,
    localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1,
    localparam int SIW = (SITES_PER_ROW > 1) ? $clog2(SITES_PER_ROW) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [SITES_PER_ROW-1:0] occ,
    input  logic                     occ_ok,
    input  logic [RW-1:0]            in_row,
    input  logic [YW-1:0]            in_y,
    input  nfsp_req_t                req,
    input  logic [SITES_PER_ROW-1:0] le,
    output nfsp_cand_t               cand,
    output logic [SIW-1:0]           cand_start,
    output logic [RW-1:0]            cand_row,
    output logic                     busy
);

    logic [SITES_PER_ROW-1:0] lv [LVL_N];
    logic [SITES_PER_ROW-1:0] c2;
    logic [SITES_PER_ROW-1:0] lft;
    logic [SITES_PER_ROW-1:0] rgt;
    logic [SIW-1:0]           ls_c;
    logic [SIW-1:0]           rs_c;
    logic [DIST_W-1:0]        dl;
    logic [DIST_W-1:0]        dr;
    logic                     pick_l;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [SITES_PER_ROW-1:0] fp1_reg, c2_reg;
    logic [RW-1:0]            row1_reg, row2_reg, row3_reg, row4_reg, row5_reg;
    logic [YW-1:0]            y1_reg, y2_reg, y3_reg, y4_reg, y5_reg;
    logic                     lhit3_reg, rhit3_reg, lhit4_reg, rhit4_reg, hit5_reg;
    logic [SIW-1:0]           ls3_reg, rs3_reg, ls4_reg, rs4_reg, s5_reg;
    logic [XW-1:0]            xl4_reg, xr4_reg, x5_reg;
    logic [CW-1:0]            dy4_reg;
    logic [DIST_W-1:0]        d5_reg;

    function automatic logic [CW-1:0] absd(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW-1:0] d;
        d = a - b;
        return d[CW-1] ? (~d + 1'b1) : d;
    endfunction

    // Free runs of length 2^j starting at each site.
    always_comb
    begin
        lv[0] = occ_ok ? ~occ : '1;
        for (int j = 1; j < LVL_N; j++)
        begin
            lv[j] = lv[j-1] & (lv[j-1] >> (1 << (j - 1)));
        end
    end

    // Two overlapping power-of-two windows cover the whole span.
    assign c2  = fp1_reg & (fp1_reg >> req.pdiff);
    assign lft = c2_reg & le;
    assign rgt = c2_reg & ~le;

    // Nearest start on each side of the wanted x.
    always_comb
    begin
        ls_c = '0;
        for (int s = 0; s < SITES_PER_ROW; s++)
        begin
            if (lft[s])
            begin
                ls_c = SIW'(s);
            end
        end
        rs_c = '0;
        for (int s = SITES_PER_ROW - 1; s >= 0; s--)
        begin
            if (rgt[s])
            begin
                rs_c = SIW'(s);
            end
        end
    end

    // Distances of both sides; the left one wins a tie.
    always_comb
    begin
        dl = DIST_W'(absd(CW'(req.wx), CW'(xl4_reg))) + DIST_W'(dy4_reg);
        dr = DIST_W'(absd(CW'(req.wx), CW'(xr4_reg))) + DIST_W'(dy4_reg);
        pick_l = lhit4_reg && (!rhit4_reg || (dl <= dr));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fp1_reg  <= lv[req.plog];
        row1_reg <= in_row;
        y1_reg   <= in_y;

        c2_reg   <= c2;
        row2_reg <= row1_reg;
        y2_reg   <= y1_reg;

        lhit3_reg <= |lft;
        rhit3_reg <= |rgt;
        ls3_reg   <= ls_c;
        rs3_reg   <= rs_c;
        row3_reg  <= row2_reg;
        y3_reg    <= y2_reg;

        lhit4_reg <= lhit3_reg;
        rhit4_reg <= rhit3_reg;
        ls4_reg   <= ls3_reg;
        rs4_reg   <= rs3_reg;
        row4_reg  <= row3_reg;
        y4_reg    <= y3_reg;
        xl4_reg   <= XW'(ls3_reg) * XW'(req.sw);
        xr4_reg   <= XW'(rs3_reg) * XW'(req.sw);
        dy4_reg   <= absd(CW'(req.wy), CW'(y3_reg));

        hit5_reg <= lhit4_reg | rhit4_reg;
        d5_reg   <= pick_l ? dl : dr;
        x5_reg   <= pick_l ? xl4_reg : xr4_reg;
        s5_reg   <= pick_l ? ls4_reg : rs4_reg;
        row5_reg <= row4_reg;
        y5_reg   <= y4_reg;
    end

    assign cand.valid = v5_reg;
    assign cand.hit   = hit5_reg;
    assign cand.cost  = d5_reg;
    assign cand.x     = x5_reg;
    assign cand.y     = y5_reg;
    assign cand_start = s5_reg;
    assign cand_row   = row5_reg;
    assign busy       = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;

endmodule

>>> rtl/nearest_free_site_span_placer.sv
// Places cells of a given width in sites on a grid of NUM_ROWS rows by
// SITES_PER_ROW sites, all free after reset, choosing the free span whose
// corner lies nearest (Manhattan distance) to the wanted point, first in
// row-major order on a tie, and reserving it. One request is handled at a
// time and goes through a serial divide that locates the wanted x among the
// sites, one occupancy row read per cycle from the grid memory, a five-stage
// row evaluator, and a read-modify-write of the chosen row. A request whose
// width is zero or wider than a row skips the divide and the scan and goes
// straight to the output state. The result word waits in an output
// register while the next request is taken. site_width and row_height sit at
// byte addresses 0 and 4 and reset to 1.
module nearest_free_site_span_placer
    import nfsp_pkg::*;
#(
    parameter int NUM_ROWS = NFSP_NUM_ROWS,
    parameter int SITES_PER_ROW = NFSP_SITES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic signed [WX_W-1:0] want_x,
    input  logic signed [WX_W-1:0] want_y,
    input  logic [SPAN_W-1:0]      span_sites,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic                   placed,
    output logic [19:0]            place_x,
    output logic [17:0]            place_y,
    output logic [21:0]            displacement
);

    localparam int RW  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int SIW = (SITES_PER_ROW > 1) ? $clog2(SITES_PER_ROW) : 1;
    localparam logic REG_SITE_WIDTH = 1'b0;
    localparam logic REG_ROW_HEIGHT = 1'b1;

    nfsp_state_t state_reg, state_next;

    logic [PITCH_W-1:0]       sw_reg, rh_reg;
    logic signed [WX_W-1:0]   wx_reg, wy_reg;
    logic [SPAN_W-1:0]        span_reg;
    logic [LVL_W-1:0]         plog_reg;
    logic [SPAN_W-1:0]        pdiff_reg;
    logic [SITES_PER_ROW-1:0] le_reg;
    logic [RW-1:0]            scan_row_reg;
    logic [YW-1:0]            y_issue_reg;
    logic                     rd_scan_reg;
    logic [RW-1:0]            rd_row_reg;
    logic [YW-1:0]            rd_y_reg;
    logic                     rd_ok_reg;
    logic [NUM_ROWS-1:0]      row_ok_reg;
    logic                     found_reg;
    logic [DIST_W-1:0]        best_d_reg;
    logic [XW-1:0]            best_x_reg;
    logic [YW-1:0]            best_y_reg;
    logic [SIW-1:0]           best_s_reg;
    logic [RW-1:0]            best_r_reg;
    logic                     rsp_valid_reg;
    logic                     placed_reg;
    logic [19:0]              place_x_reg;
    logic [17:0]              place_y_reg;
    logic [21:0]              disp_reg;

    logic                     cfg_wr;
    logic                     req_ok;
    logic                     span_bad;
    logic                     rsp_load;
    logic                     div_done;
    logic [DIVQ_W-1:0]        div_q;
    logic                     mem_we;
    logic [RW-1:0]            mem_addr;
    logic [SITES_PER_ROW-1:0] mem_wdata;
    logic [SITES_PER_ROW-1:0] mem_rdata;
    logic [SITES_PER_ROW-1:0] span_mask;
    logic [SITES_PER_ROW-1:0] le_c;
    nfsp_req_t                req_info;
    nfsp_cand_t               cand;
    logic [SIW-1:0]           cand_start;
    logic [RW-1:0]            cand_row;
    logic                     eval_busy;
    logic                     last_row;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = {20'b0, (paddr[2] == REG_ROW_HEIGHT) ? rh_reg : sw_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= PITCH_W'(1);
            rh_reg <= PITCH_W'(1);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SITE_WIDTH)
            begin
                sw_reg <= pwdata[PITCH_W-1:0];
            end
            else
            begin
                rh_reg <= pwdata[PITCH_W-1:0];
            end
        end
    end

    // Request handshake.
    assign req_stall = (state_reg != ST_IDLE);
    assign req_ok    = req_valid && !req_stall;
    assign span_bad  = (span_sites == '0) || (int'(span_sites) > SITES_PER_ROW);
    assign rsp_load  = !rsp_valid_reg || !rsp_stall;
    assign last_row  = (scan_row_reg == RW'(NUM_ROWS - 1));

    // Divider finds the last site whose corner is not right of the wanted x.
    nfsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (req_ok && !span_bad),
        .dividend (want_x[DIVQ_W-1:0]),
        .divisor  ((sw_reg == '0) ? PITCH_W'(1) : sw_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Starts on the left of the wanted x; with a zero pitch all count as right.
    always_comb
    begin
        for (int s = 0; s < SITES_PER_ROW; s++)
        begin
            le_c[s] = !wx_reg[WX_W-1] && (sw_reg != '0) && (DIVQ_W'(s) <= div_q);
        end
    end

    // Sites covered by the chosen span.
    always_comb
    begin
        for (int s = 0; s < SITES_PER_ROW; s++)
        begin
            span_mask[s] = (s >= int'(best_s_reg)) &&
                           (s < int'(best_s_reg) + int'(span_reg));
        end
    end

    // Grid memory port.
    always_comb
    begin
        mem_addr  = scan_row_reg;
        mem_we    = 1'b0;
        mem_wdata = (rd_ok_reg ? mem_rdata : '0) | span_mask;
        if (state_reg == ST_WB_RD || state_reg == ST_WB_WR)
        begin
            mem_addr = best_r_reg;
        end
        if (state_reg == ST_WB_WR)
        begin
            mem_we = 1'b1;
        end
    end

    nfsp_ram #(
        .WIDTH (SITES_PER_ROW),
        .DEPTH (NUM_ROWS)
    ) u_grid (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign req_info.wx    = wx_reg;
    assign req_info.wy    = wy_reg;
    assign req_info.sw    = sw_reg;
    assign req_info.plog  = plog_reg;
    assign req_info.pdiff = pdiff_reg;

    nfsp_eval #(
        .NUM_ROWS      (NUM_ROWS),
        .SITES_PER_ROW (SITES_PER_ROW)
    ) u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rd_scan_reg),
        .occ        (mem_rdata),
        .occ_ok     (rd_ok_reg),
        .in_row     (rd_row_reg),
        .in_y       (rd_y_reg),
        .req        (req_info),
        .le         (le_reg),
        .cand       (cand),
        .cand_start (cand_start),
        .cand_row   (cand_row),
        .busy       (eval_busy)
    );

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_ok)
                begin
                    state_next = span_bad ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_MASK;
                end
            end
            ST_MASK:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (last_row)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_scan_reg && !eval_busy)
                begin
                    state_next = found_reg ? ST_WB_RD : ST_OUT;
                end
            end
            ST_WB_RD:
            begin
                state_next = ST_WB_WR;
            end
            ST_WB_WR:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers: read tags, row valid bits, best flag, response valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_scan_reg   <= 1'b0;
            row_ok_reg    <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rd_scan_reg <= (state_reg == ST_SCAN);
            if (mem_we)
            begin
                row_ok_reg[best_r_reg] <= 1'b1;
            end
            if (req_ok)
            begin
                found_reg <= 1'b0;
            end
            else if (cand.valid && cand.hit && (!found_reg || cand.cost < best_d_reg))
            begin
                found_reg <= 1'b1;
            end
            if (state_reg == ST_OUT && rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (req_ok)
        begin
            wx_reg    <= want_x;
            wy_reg    <= want_y;
            span_reg  <= span_sites;
            plog_reg  <= msb_pos(span_sites);
            pdiff_reg <= span_sites - (SPAN_W'(1) << msb_pos(span_sites));
        end
        if (state_reg == ST_MASK)
        begin
            le_reg       <= le_c;
            scan_row_reg <= '0;
            y_issue_reg  <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            scan_row_reg <= scan_row_reg + 1'b1;
            y_issue_reg  <= y_issue_reg + YW'(rh_reg);
        end
        rd_row_reg <= mem_addr;
        rd_y_reg   <= y_issue_reg;
        rd_ok_reg  <= row_ok_reg[mem_addr];
        if (cand.valid && cand.hit && (!found_reg || cand.cost < best_d_reg))
        begin
            best_d_reg <= cand.cost;
            best_x_reg <= cand.x;
            best_y_reg <= cand.y;
            best_s_reg <= cand_start;
            best_r_reg <= cand_row;
        end
        if (state_reg == ST_OUT && rsp_load)
        begin
            placed_reg  <= found_reg;
            place_x_reg <= found_reg ? best_x_reg[19:0] : '0;
            place_y_reg <= found_reg ? best_y_reg[17:0] : '0;
            if (!found_reg)
            begin
                disp_reg <= '0;
            end
            else if (best_d_reg > DIST_W'(DISP_MAX))
            begin
                disp_reg <= DISP_MAX;
            end
            else
            begin
                disp_reg <= best_d_reg[21:0];
            end
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign placed       = placed_reg;
    assign place_x      = place_x_reg;
    assign place_y      = place_y_reg;
    assign displacement = disp_reg;

endmodule
